### hw/rtl/sca_pkg.sv
// Shared types and constants for the sparse coordinate-list matrix adder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sca_pkg;

	localparam int ROW_W      = 16;
	localparam int COL_W      = 16;
	localparam int VAL_W      = 32;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Request operation codes.
	localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

	// One stored list entry, 64 bits.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} term_t;

	// Decision of one merge step.
	typedef struct packed {
		logic  take_a;
		logic  take_b;
		term_t term;
	} pick_t;

endpackage

`default_nettype wire

### hw/rtl/sca_ifs.sv
// Handshake channels of the sparse matrix adder: request and result.
// Depends on sca_pkg for the field widths.
`default_nettype none

interface sca_cmd_if;
	import sca_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic [ROW_W-1:0]        row;
	logic [COL_W-1:0]        col;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, op, row, col, value, input ready);
	modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface sca_rsp_if;
	import sca_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [ROW_W-1:0]        out_row;
	logic [COL_W-1:0]        out_col;
	logic signed [VAL_W-1:0] out_value;
	logic                    has_entry;
	logic                    last;

	modport source (output valid, out_row, out_col, out_value, has_entry, last, input ready);
	modport sink   (input valid, out_row, out_col, out_value, has_entry, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/sca_pick.sv
// Merge step decision: compares the two list heads in row-major order.
// Depends on sca_pkg for term_t and pick_t.
`default_nettype none

module sca_pick (
	input  logic           a_avail,
	input  logic           b_avail,
	input  sca_pkg::term_t head_a,
	input  sca_pkg::term_t head_b,
	output sca_pkg::pick_t pick
);
	import sca_pkg::*;

	logic [ROW_W+COL_W-1:0] key_a;
	logic [ROW_W+COL_W-1:0] key_b;
	logic                   a_first;
	logic                   b_first;
	logic                   both;

	assign key_a = {head_a.row, head_a.col};
	assign key_b = {head_b.row, head_b.col};

	assign a_first = a_avail && (!b_avail || (key_a < key_b));
	assign b_first = b_avail && (!a_avail || (key_b < key_a));
	assign both    = a_avail && b_avail && (key_a == key_b);

	always_comb begin
		pick.take_a = a_first || both;
		pick.take_b = b_first || both;
		if (both) begin
			pick.term       = head_a;
			pick.term.value = head_a.value + head_b.value;
		end else if (a_first) begin
			pick.term = head_a;
		end else if (b_first) begin
			pick.term = head_b;
		end else begin
			pick.term = '0;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sparse_coo_matrix_add.sv
// Sparse matrix addition over two coordinate lists (row, column, value).
// Depends on sca_pkg, the channel interfaces in sca_ifs.sv and sca_pick.
//
// Usage: requests arrive on cmd. A request with op load A or load B appends
// one entry to the matching list (up to MAX_TERMS entries each; loads into a
// full list are dropped). Loads are taken one per cycle while no run is
// in progress, and give no result. A run request merges the two lists in
// row-major order onto rsp, one result per merged entry, with last set on
// the final one. Equal positions are summed with 32-bit wrap. If the
// configured dimensions of A and B differ, list A is sent unchanged. A run
// with nothing to send gives a single result with has_entry low. Both lists
// are empty after a run. Each merge step is registered in the result
// register, one result per cycle while rsp is ready; cmd is not ready during
// a run. The rate is set by the single read port of each list memory, which
// delivers one head per cycle. When rsp stalls, the merge holds in place and
// the result register keeps its value. Reset clears both counts and the
// result valid, and sets all four dimension registers to 1. Configuration
// is written through cfg_wr_en, cfg_index and cfg_data; the user must do so
// only while no run is in progress, which the block itself does not enforce.
`default_nettype none

module sparse_coo_matrix_add #(
	parameter int MAX_TERMS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sca_cmd_if.sink                          cmd,
	sca_rsp_if.source                        rsp,
	input  logic                             cfg_wr_en,
	input  logic [sca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sca_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sca_pkg::*;

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);

	typedef enum logic {ST_IDLE, ST_MERGE} state_t;

	// Dimension registers.
	logic [CFG_DATA_W-1:0] a_rows_q;
	logic [CFG_DATA_W-1:0] a_cols_q;
	logic [CFG_DATA_W-1:0] b_rows_q;
	logic [CFG_DATA_W-1:0] b_cols_q;

	// The two list memories, each with one write and one registered read port.
	term_t mem_a [MAX_TERMS];
	term_t mem_b [MAX_TERMS];
	term_t rd_a_q;
	term_t rd_b_q;

	state_t         state_q;
	logic [CW-1:0]  count_a_q;
	logic [CW-1:0]  count_b_q;
	logic [CW-1:0]  idx_a_q;
	logic [CW-1:0]  idx_b_q;
	logic           mism_q;
	logic           rsp_valid_q;
	term_t          rsp_term_q;
	logic           rsp_has_q;
	logic           rsp_last_q;

	logic           cmd_acc;
	logic           load_a;
	logic           load_b;
	logic           run_acc;
	logic           slot_free;
	logic           a_avail;
	logic           b_avail;
	logic           emit;
	logic           is_last;
	logic [CW-1:0]  idx_a_nx;
	logic [CW-1:0]  idx_b_nx;
	term_t          load_term;
	pick_t          pick;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign load_a    = cmd_acc && (cmd.op == OP_LOAD_A) && (count_a_q != FULL);
	assign load_b    = cmd_acc && (cmd.op == OP_LOAD_B) && (count_b_q != FULL);
	assign run_acc   = cmd_acc && (cmd.op == OP_RUN);

	assign load_term.row   = cmd.row;
	assign load_term.col   = cmd.col;
	assign load_term.value = cmd.value;

	// A list head is live while its index is below the count. Under a
	// dimension mismatch list B is treated as empty.
	assign a_avail = (idx_a_q < count_a_q);
	assign b_avail = !mism_q && (idx_b_q < count_b_q);

	sca_pick u_pick (
		.a_avail (a_avail),
		.b_avail (b_avail),
		.head_a  (rd_a_q),
		.head_b  (rd_b_q),
		.pick    (pick)
	);

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign emit      = (state_q == ST_MERGE) && slot_free;

	assign idx_a_nx = idx_a_q + CW'(emit && pick.take_a);
	assign idx_b_nx = idx_b_q + CW'(emit && pick.take_b);

	// The step is final once neither list has anything left behind it. With
	// both lists empty this holds on the first step, which sends the empty
	// result.
	assign is_last = !((idx_a_nx < count_a_q) || (!mism_q && (idx_b_nx < count_b_q)));

	// The read address follows the next index, so the registered read data
	// always holds the current head. Indexes sit at zero while idle, which
	// primes entry zero for the start of a run.
	always_ff @(posedge clk) begin
		if (load_a) begin
			mem_a[count_a_q[AW-1:0]] <= load_term;
		end
		if (load_b) begin
			mem_b[count_b_q[AW-1:0]] <= load_term;
		end
		rd_a_q <= mem_a[idx_a_nx[AW-1:0]];
		rd_b_q <= mem_b[idx_b_nx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= CFG_DATA_W'(1);
			a_cols_q <= CFG_DATA_W'(1);
			b_rows_q <= CFG_DATA_W'(1);
			b_cols_q <= CFG_DATA_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_A_ROWS: a_rows_q <= cfg_data;
				REG_A_COLS: a_cols_q <= cfg_data;
				REG_B_ROWS: b_rows_q <= cfg_data;
				REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			idx_a_q     <= '0;
			idx_b_q     <= '0;
			mism_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_term_q  <= '0;
			rsp_has_q   <= 1'b0;
			rsp_last_q  <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (load_a) begin
						count_a_q <= count_a_q + CW'(1);
					end
					if (load_b) begin
						count_b_q <= count_b_q + CW'(1);
					end
					if (run_acc) begin
						mism_q  <= (a_rows_q != b_rows_q) || (a_cols_q != b_cols_q);
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (emit) begin
						rsp_term_q <= pick.term;
						rsp_has_q  <= pick.take_a || pick.take_b;
						rsp_last_q <= is_last;
						if (is_last) begin
							state_q   <= ST_IDLE;
							count_a_q <= '0;
							count_b_q <= '0;
							idx_a_q   <= '0;
							idx_b_q   <= '0;
						end else begin
							idx_a_q <= idx_a_nx;
							idx_b_q <= idx_b_nx;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_row   = rsp_term_q.row;
	assign rsp.out_col   = rsp_term_q.col;
	assign rsp.out_value = rsp_term_q.value;
	assign rsp.has_entry = rsp_has_q;
	assign rsp.last      = rsp_last_q;

	// The lists never hold more than their capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_a_q <= FULL) && (count_b_q <= FULL))
		else $error("list count beyond capacity");

	// A merge step with a live head always consumes at least one head.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MERGE) && (a_avail || b_avail)) |-> (pick.take_a || pick.take_b))
		else $error("merge step consumed no head");

	// The final result of a run leaves both lists empty and the block idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_last) |=> ((state_q == ST_IDLE) && (count_a_q == '0) &&
		(count_b_q == '0) && rsp_last_q))
		else $error("run did not finish cleanly");

	// Merge indexes never pass the counts.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> ((idx_a_q <= count_a_q) && (idx_b_q <= count_b_q)))
		else $error("merge index beyond list count");

endmodule

`default_nettype wire
